>>> rtl/usc_pkg.sv
// Shared types and constants of the ultrasonic occupancy scanner.
package usc_pkg;

    localparam int NUM_SPOTS     = 4;
    localparam int SPOT_W        = $clog2(NUM_SPOTS);
    localparam int CONFIRM_COUNT = 3;
    localparam int CNT_W         = $clog2(CONFIRM_COUNT + 1);
    localparam int FREE_W        = $clog2(NUM_SPOTS + 1);
    localparam int TIME_W        = 32;
    localparam int LINES_W       = 4;
    localparam int DIST_W        = 12;
    localparam int TIMEOUT_W     = 20;
    localparam int SCALE_W       = 16;
    localparam int SCALE_FRAC    = 16;
    localparam int CFG_DATA_W    = 20;
    localparam int CFG_IDX_W     = 2;
    localparam int PROD_W        = TIME_W + SCALE_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_THRESHOLD  = 2'd0,
        REG_OFF_THRESHOLD = 2'd1,
        REG_ECHO_TIMEOUT  = 2'd2,
        REG_SCALE         = 2'd3
    } cfg_index_t;

    localparam logic [DIST_W-1:0]    RST_ON_THRESHOLD  = 12'd10;
    localparam logic [DIST_W-1:0]    RST_OFF_THRESHOLD = 12'd15;
    localparam logic [TIMEOUT_W-1:0] RST_ECHO_TIMEOUT  = 20'd30000;
    localparam logic [SCALE_W-1:0]   RST_SCALE         = 16'd1124;

    // Current configuration, as seen by the datapath.
    typedef struct packed {
        logic [DIST_W-1:0]    on_threshold_cm;
        logic [DIST_W-1:0]    off_threshold_cm;
        logic [TIMEOUT_W-1:0] echo_timeout_us;
        logic [SCALE_W-1:0]   cm_per_us_q16;
    } cfg_t;

    // Outcome of one ranging step.
    typedef struct packed {
        logic              trigger_pulse;
        logic [SPOT_W-1:0] active_spot;
        logic              reading_done;
        logic              reading_valid;
        logic [DIST_W-1:0] distance_cm;
    } reading_t;

endpackage

>>> rtl/ultrasonic_occupancy_scanner_core.sv
// Top level of the ultrasonic occupancy scanner: input stage, step logic, result stage.
// A request waits in the input stage; its result is then registered in the result stage.
// Throughput: one request per cycle while results are taken; the input stage refills whenever its
// request moves on into the result register.
// Reset: rst_n clears all control state at once, loads the register defaults,
// and puts the ranger to idle with the scan at spot 0 and all spots free.
module ultrasonic_occupancy_scanner_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [usc_pkg::TIME_W-1:0]        time_us,
    input  logic [usc_pkg::LINES_W-1:0]       echo_lines,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              trigger_pulse,
    output logic [usc_pkg::SPOT_W-1:0]        active_spot,
    output logic                              reading_done,
    output logic                              reading_valid,
    output logic [usc_pkg::DIST_W-1:0]        distance_cm,
    output logic [usc_pkg::NUM_SPOTS-1:0]     occupied_map,
    output logic [usc_pkg::FREE_W-1:0]        free_spots,
    input  logic                              cfg_we,
    input  logic [usc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [usc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import usc_pkg::*;

    cfg_t                 cfg;
    reading_t             reading;
    logic [NUM_SPOTS-1:0] occ_next;
    logic [FREE_W-1:0]    free_next;

    logic                 in_full_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [LINES_W-1:0]   lines_reg;
    logic                 out_full_reg;
    reading_t             res_reading_reg;
    logic [NUM_SPOTS-1:0] res_occ_reg;
    logic [FREE_W-1:0]    res_free_reg;
    logic                 advance;

    // The held request is processed when the result register can take it.
    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    usc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    usc_ranger u_ranger
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .time_us    (time_reg),
        .echo_lines (lines_reg),
        .cfg        (cfg),
        .reading    (reading)
    );

    usc_hysteresis u_hyst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .reading       (reading),
        .cfg           (cfg),
        .occupied_next (occ_next),
        .free_next     (free_next)
    );

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_ready)
            in_full_reg <= in_valid;
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            time_reg  <= time_us;
            lines_reg <= echo_lines;
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (advance)
            out_full_reg <= 1'b1;
        else if (out_ready)
            out_full_reg <= 1'b0;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reading_reg <= reading;
            res_occ_reg     <= occ_next;
            res_free_reg    <= free_next;
        end
    end

    assign out_valid     = out_full_reg;
    assign trigger_pulse = res_reading_reg.trigger_pulse;
    assign active_spot   = res_reading_reg.active_spot;
    assign reading_done  = res_reading_reg.reading_done;
    assign reading_valid = res_reading_reg.reading_valid;
    assign distance_cm   = res_reading_reg.distance_cm;
    assign occupied_map  = res_occ_reg;
    assign free_spots    = res_free_reg;

`ifndef ASSERT_OFF
    // A valid reading is always a finished one, and a trigger step finishes nothing.
    a_valid_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!reading_valid || reading_done) && !(trigger_pulse && reading_done))
        else $error("reading flags inconsistent");

    // Free count and occupancy map always account for every spot.
    a_free_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(free_spots) + $countones(occupied_map)) == NUM_SPOTS)
        else $error("free count disagrees with occupancy map");

    // A stalled result keeps the input stage from being overwritten.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready && in_full_reg) |-> !in_ready)
        else $error("input accepted while both stages are full");

    // An invalid or missing reading carries no distance.
    a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reading_valid) |-> (distance_cm == '0))
        else $error("distance reported without a valid reading");
`endif

endmodule

>>> rtl/usc_cfg_regs.sv
// Configuration register file of the occupancy scanner.
module usc_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [usc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [usc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output usc_pkg::cfg_t                     cfg
);
    import usc_pkg::*;

    cfg_t cfg_reg;

    // Decode the register index and store the masked write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold_cm  <= RST_ON_THRESHOLD;
            cfg_reg.off_threshold_cm <= RST_OFF_THRESHOLD;
            cfg_reg.echo_timeout_us  <= RST_ECHO_TIMEOUT;
            cfg_reg.cm_per_us_q16    <= RST_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ON_THRESHOLD:  cfg_reg.on_threshold_cm  <= cfg_data[DIST_W-1:0];
                REG_OFF_THRESHOLD: cfg_reg.off_threshold_cm <= cfg_data[DIST_W-1:0];
                REG_ECHO_TIMEOUT:  cfg_reg.echo_timeout_us  <= cfg_data[TIMEOUT_W-1:0];
                REG_SCALE:         cfg_reg.cm_per_us_q16    <= cfg_data[SCALE_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/usc_ranger.sv
// Echo ranging sequencer: trigger, echo rise and echo fall per spot.
module usc_ranger
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic [usc_pkg::TIME_W-1:0]      time_us,
    input  logic [usc_pkg::LINES_W-1:0]     echo_lines,
    input  usc_pkg::cfg_t                   cfg,
    output usc_pkg::reading_t               reading
);
    import usc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_WAIT_RISE = 3'b010,
        PH_WAIT_FALL = 3'b100
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [SPOT_W-1:0]   spot_reg, spot_next;
    logic [TIME_W-1:0]   mark_reg, mark_next;

    logic                echo;
    logic [TIME_W-1:0]   elapsed;
    logic                timed_out;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-SCALE_FRAC-1:0] scaled;
    logic [DIST_W-1:0]   dist_sat;
    logic                trig;
    logic                done;
    logic                valid;

    // Echo level of the current spot and time since the last mark, mod 2^32.
    assign echo      = echo_lines[spot_reg];
    assign elapsed   = time_us - mark_reg;
    assign timed_out = (elapsed >= TIME_W'(cfg.echo_timeout_us));

    // Distance: duration times scale, fraction dropped, saturated.
    assign product  = PROD_W'(elapsed) * PROD_W'(cfg.cm_per_us_q16);
    assign scaled   = product[PROD_W-1:SCALE_FRAC];
    assign dist_sat = (|scaled[PROD_W-SCALE_FRAC-1:DIST_W]) ? DIST_MAX : scaled[DIST_W-1:0];

    // Phase sequencing for one step.
    always_comb
    begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        trig       = 1'b0;
        done       = 1'b0;
        valid      = 1'b0;
        unique case (phase_reg)
            PH_WAIT_RISE:
            begin
                if (echo)
                begin
                    mark_next  = time_us;
                    phase_next = PH_WAIT_FALL;
                end
                else if (timed_out)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_WAIT_FALL:
            begin
                if (!echo)
                begin
                    valid      = (time_us > mark_reg);
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (timed_out)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                trig       = 1'b1;
                mark_next  = time_us;
                phase_next = PH_WAIT_RISE;
            end
        endcase
    end

    // A finished reading moves the scan on to the next spot.
    always_comb
    begin
        spot_next = spot_reg;
        if (done)
        begin
            if (spot_reg == SPOT_W'(NUM_SPOTS - 1))
                spot_next = '0;
            else
                spot_next = spot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            spot_reg  <= '0;
            mark_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            spot_reg  <= spot_next;
            mark_reg  <= mark_next;
        end
    end

    assign reading.trigger_pulse = trig;
    assign reading.active_spot   = spot_reg;
    assign reading.reading_done  = done;
    assign reading.reading_valid = valid;
    assign reading.distance_cm   = valid ? dist_sat : '0;

endmodule

>>> rtl/usc_hysteresis.sv
// Per-spot two-threshold hysteresis and the confirmed occupancy map.
module usc_hysteresis
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step_en,
    input  usc_pkg::reading_t                  reading,
    input  usc_pkg::cfg_t                      cfg,
    output logic [usc_pkg::NUM_SPOTS-1:0]      occupied_next,
    output logic [usc_pkg::FREE_W-1:0]         free_next
);
    import usc_pkg::*;

    logic [CNT_W-1:0]     near_reg [NUM_SPOTS];
    logic [CNT_W-1:0]     far_reg  [NUM_SPOTS];
    logic [NUM_SPOTS-1:0] occ_reg;

    logic [CNT_W-1:0]     near_upd, far_upd;
    logic [CNT_W:0]       near_inc, far_inc;
    logic                 occ_upd;
    logic                 is_near, is_far;
    logic [SPOT_W-1:0]    s;

    assign s        = reading.active_spot;
    assign is_near  = !reading.reading_valid || (reading.distance_cm < cfg.on_threshold_cm);
    assign is_far   = !is_near && (reading.distance_cm > cfg.off_threshold_cm);
    assign near_inc = {1'b0, near_reg[s]} + 1'b1;
    assign far_inc  = {1'b0, far_reg[s]} + 1'b1;

    // Update the counters of the spot whose reading just finished.
    always_comb
    begin
        near_upd = '0;
        far_upd  = '0;
        occ_upd  = occ_reg[s];
        if (is_near)
        begin
            if (near_inc >= (CNT_W+1)'(CONFIRM_COUNT))
            begin
                near_upd = CNT_W'(CONFIRM_COUNT);
                occ_upd  = 1'b1;
            end
            else
                near_upd = near_inc[CNT_W-1:0];
        end
        else if (is_far)
        begin
            if (far_inc >= (CNT_W+1)'(CONFIRM_COUNT))
            begin
                far_upd = CNT_W'(CONFIRM_COUNT);
                occ_upd = 1'b0;
            end
            else
                far_upd = far_inc[CNT_W-1:0];
        end
    end

    // Map after this step, and the number of spots confirmed free.
    always_comb
    begin
        occupied_next = occ_reg;
        if (reading.reading_done)
            occupied_next[s] = occ_upd;
        free_next = '0;
        for (int i = 0; i < NUM_SPOTS; i++)
        begin
            if (!occupied_next[i])
                free_next = free_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SPOTS; i++)
            begin
                near_reg[i] <= '0;
                far_reg[i]  <= '0;
            end
            occ_reg <= '0;
        end
        else if (step_en && reading.reading_done)
        begin
            near_reg[s] <= near_upd;
            far_reg[s]  <= far_upd;
            occ_reg     <= occupied_next;
        end
    end

endmodule

>>> dv/occupancy_scan_checker.sv
// Checker for the ultrasonic occupancy scanner: models each scan step and compares results.
`timescale 1ns / 100ps

module occupancy_scan_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [usc_pkg::TIME_W-1:0]        time_us,
    input  logic [usc_pkg::LINES_W-1:0]       echo_lines,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              trigger_pulse,
    input  logic [usc_pkg::SPOT_W-1:0]        active_spot,
    input  logic                              reading_done,
    input  logic                              reading_valid,
    input  logic [usc_pkg::DIST_W-1:0]        distance_cm,
    input  logic [usc_pkg::NUM_SPOTS-1:0]     occupied_map,
    input  logic [usc_pkg::FREE_W-1:0]        free_spots,
    input  logic                              cfg_we,
    input  logic [usc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [usc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                pending_results,
    output int                                results_checked,
    output int                                readings_seen
);

    import usc_pkg::*;

    typedef enum logic [1:0] {
        SCAN_TRIGGER   = 2'd0,
        SCAN_WAIT_RISE = 2'd1,
        SCAN_WAIT_FALL = 2'd2
    } scan_phase_t;

    // One full result of a scan step.
    typedef struct packed {
        reading_t              rd;
        logic [NUM_SPOTS-1:0]  map;
        logic [FREE_W-1:0]     nfree;
    } scan_result_t;

    // Shadow of the block's registers and scan state.
    cfg_t                  setting;
    scan_phase_t           phase;
    logic [SPOT_W-1:0]     spot;
    logic [TIME_W-1:0]     mark_us;
    int                    near_run [NUM_SPOTS];
    int                    far_run  [NUM_SPOTS];
    logic [NUM_SPOTS-1:0]  occupied;

    scan_result_t          expected_scans [$];
    scan_result_t          want;
    scan_result_t          got;

    // Prints one mismatch line (up to a cap) and counts it.
    task report_mismatch(input string what, input longint unsigned got_v,
                         input longint unsigned want_v);
        if (fail_count < 40)
            $display("%t checker: %s: got %0d, expected %0d", $time, what, got_v, want_v);
        fail_count++;
    endtask

    // Advances the shadow by one scan step and returns the result it must produce.
    task scan_step(input logic [TIME_W-1:0] now, input logic [LINES_W-1:0] lines,
                   output scan_result_t r);
        logic              echo;
        logic [TIME_W-1:0] elapsed;
        logic [PROD_W-1:0] prod;
        logic              finished;
        r = '0;
        r.rd.active_spot = spot;
        echo     = lines[spot];
        elapsed  = now - mark_us;
        finished = 1'b0;
        case (phase)
            SCAN_WAIT_RISE:
            begin
                // A rising echo is taken before any timeout check.
                if (echo)
                begin
                    mark_us = now;
                    phase   = SCAN_WAIT_FALL;
                end
                else if (elapsed >= TIME_W'(setting.echo_timeout_us))
                begin
                    finished = 1'b1;
                    phase    = SCAN_TRIGGER;
                end
            end
            SCAN_WAIT_FALL:
            begin
                if (!echo)
                begin
                    // Only a fall strictly later than the rise gives a valid reading.
                    if (now > mark_us)
                    begin
                        prod = PROD_W'(elapsed) * PROD_W'(setting.cm_per_us_q16);
                        r.rd.reading_valid = 1'b1;
                        r.rd.distance_cm   = ((prod >> SCALE_FRAC) > PROD_W'(DIST_MAX)) ?
                                             DIST_MAX : prod[SCALE_FRAC +: DIST_W];
                    end
                    finished = 1'b1;
                    phase    = SCAN_TRIGGER;
                end
                else if (elapsed >= TIME_W'(setting.echo_timeout_us))
                begin
                    finished = 1'b1;
                    phase    = SCAN_TRIGGER;
                end
            end
            default:
            begin
                r.rd.trigger_pulse = 1'b1;
                mark_us = now;
                phase   = SCAN_WAIT_RISE;
            end
        endcase
        r.rd.reading_done = finished;

        // Hysteresis on the finished reading, then move on to the next spot.
        if (finished)
        begin
            if (!r.rd.reading_valid || r.rd.distance_cm < setting.on_threshold_cm)
            begin
                near_run[spot]++;
                far_run[spot] = 0;
            end
            else if (r.rd.distance_cm > setting.off_threshold_cm)
            begin
                far_run[spot]++;
                near_run[spot] = 0;
            end
            else
            begin
                near_run[spot] = 0;
                far_run[spot]  = 0;
            end
            if (near_run[spot] >= CONFIRM_COUNT)
            begin
                occupied[spot] = 1'b1;
                near_run[spot] = CONFIRM_COUNT;
            end
            if (far_run[spot] >= CONFIRM_COUNT)
            begin
                occupied[spot] = 1'b0;
                far_run[spot]  = CONFIRM_COUNT;
            end
            spot = (spot == SPOT_W'(NUM_SPOTS - 1)) ? '0 : spot + 1'b1;
            readings_seen++;
        end
        r.map   = occupied;
        r.nfree = FREE_W'($countones(~occupied));
    endtask

    // Watches both channels and the register port.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setting  = '{RST_ON_THRESHOLD, RST_OFF_THRESHOLD, RST_ECHO_TIMEOUT, RST_SCALE};
            phase    = SCAN_TRIGGER;
            spot     = '0;
            mark_us  = '0;
            occupied = '0;
            for (int i = 0; i < NUM_SPOTS; i++)
            begin
                near_run[i] = 0;
                far_run[i]  = 0;
            end
            expected_scans.delete();
            fail_count      = 0;
            results_checked = 0;
            readings_seen   = 0;
            pending_results <= 0;
        end
        else
        begin
            // Result side: compare against the oldest prediction.
            if (out_valid && out_ready)
            begin
                got.rd.trigger_pulse = trigger_pulse;
                got.rd.active_spot   = active_spot;
                got.rd.reading_done  = reading_done;
                got.rd.reading_valid = reading_valid;
                got.rd.distance_cm   = distance_cm;
                got.map              = occupied_map;
                got.nfree            = free_spots;
                if (expected_scans.size() == 0)
                    report_mismatch("result with no request outstanding", 0, 0);
                else
                begin
                    want = expected_scans.pop_front();
                    if (got.rd.trigger_pulse !== want.rd.trigger_pulse)
                        report_mismatch("trigger_pulse", got.rd.trigger_pulse,
                                        want.rd.trigger_pulse);
                    if (got.rd.active_spot !== want.rd.active_spot)
                        report_mismatch("active_spot", got.rd.active_spot, want.rd.active_spot);
                    if (got.rd.reading_done !== want.rd.reading_done)
                        report_mismatch("reading_done", got.rd.reading_done,
                                        want.rd.reading_done);
                    if (got.rd.reading_valid !== want.rd.reading_valid)
                        report_mismatch("reading_valid", got.rd.reading_valid,
                                        want.rd.reading_valid);
                    if (got.rd.distance_cm !== want.rd.distance_cm)
                        report_mismatch("distance_cm", got.rd.distance_cm, want.rd.distance_cm);
                    if (got.map !== want.map)
                        report_mismatch("occupied_map", got.map, want.map);
                    if (got.nfree !== want.nfree)
                        report_mismatch("free_spots", got.nfree, want.nfree);
                    results_checked++;
                end
            end

            // Request side: predict the result of each accepted step.
            if (in_valid && in_ready)
            begin
                scan_step(time_us, echo_lines, want);
                expected_scans.push_back(want);
            end

            // Register writes take effect for the following steps.
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_ON_THRESHOLD:  setting.on_threshold_cm  = cfg_data[DIST_W-1:0];
                    REG_OFF_THRESHOLD: setting.off_threshold_cm = cfg_data[DIST_W-1:0];
                    REG_ECHO_TIMEOUT:  setting.echo_timeout_us  = cfg_data[TIMEOUT_W-1:0];
                    REG_SCALE:         setting.cm_per_us_q16    = cfg_data[SCALE_W-1:0];
                    default:           ;
                endcase
            end
            pending_results <= expected_scans.size();
        end
    end

endmodule

>>> dv/tb_ultrasonic_occupancy_scanner_core.sv
// Testbench top for the ultrasonic occupancy scanner: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb_ultrasonic_occupancy_scanner_core;

    import usc_pkg::*;

    localparam int DIRECTED_ITEMS = 26;
    localparam int PHASE_ITEMS    = 190;
    localparam int NUM_PHASES     = 6;
    localparam int TAIL_ITEMS     = 135;
    localparam int MAX_WAITS      = 3;

    typedef enum logic [1:0] {
        MEAS_VALID,
        MEAS_RISE_TIMEOUT,
        MEAS_FALL_TIMEOUT
    } meas_kind_t;

    // What kind of reading a spot is being pushed towards.
    typedef enum logic [2:0] {
        BIAS_NEAR,
        BIAS_FAR,
        BIAS_BETWEEN,
        BIAS_BAD,
        BIAS_WILD
    } spot_bias_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [TIME_W-1:0]      time_us    = '0;
    logic [LINES_W-1:0]     echo_lines = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic                   trigger_pulse;
    logic [SPOT_W-1:0]      active_spot;
    logic                   reading_done;
    logic                   reading_valid;
    logic [DIST_W-1:0]      distance_cm;
    logic [NUM_SPOTS-1:0]   occupied_map;
    logic [FREE_W-1:0]      free_spots;
    logic                   cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index  = REG_ON_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    int                     fail_count;
    int                     pending_results;
    int                     results_checked;
    int                     readings_seen;

    // Stimulus bookkeeping.
    cfg_t                   cur_cfg;
    logic [SPOT_W-1:0]      scan_spot;
    logic [TIME_W-1:0]      now_us;
    int                     items_sent;
    int                     burst_left;
    spot_bias_t             spot_bias [NUM_SPOTS];

    ultrasonic_occupancy_scanner_core dut (.*);

    occupancy_scan_checker scan_checker (.*);

    always #4 clk = ~clk;

    // Idle length: mostly none or short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random echo lines with the scanned spot's line forced to a level.
    function automatic logic [LINES_W-1:0] echo_with(input logic [SPOT_W-1:0] s,
                                                     input logic level);
        logic [LINES_W-1:0] v;
        v    = LINES_W'($urandom());
        v[s] = level;
        return v;
    endfunction

    // Elapsed time that reaches the echo timeout, at the edge or beyond.
    function automatic logic [TIME_W-1:0] past_limit();
        logic [TIME_W-1:0] lim;
        lim = TIME_W'(cur_cfg.echo_timeout_us);
        case ($urandom_range(0, 2))
            0:       return lim;
            1:       return lim + $urandom_range(1, 100);
            default: return lim + $urandom_range(0, 32'h7FFF_FFFF);
        endcase
    endfunction

    // Echo length that aims the reading at the given bias under the current scale.
    function automatic logic [TIME_W-1:0] fall_duration(input spot_bias_t b);
        longint unsigned d;
        longint unsigned dur;
        int unsigned     on_t;
        int unsigned     off_t;
        int unsigned     sc;
        on_t  = cur_cfg.on_threshold_cm;
        off_t = cur_cfg.off_threshold_cm;
        sc    = cur_cfg.cm_per_us_q16;
        case (b)
            BIAS_NEAR:
                d = (on_t == 0) ? 0 : $urandom_range(0, on_t - 1);
            BIAS_FAR:
                d = (off_t >= 4095) ? 4095 :
                    $urandom_range(off_t + 1, (off_t + 40 > 4095) ? 4095 : off_t + 40);
            BIAS_BETWEEN:
                d = (on_t <= off_t) ? $urandom_range(on_t, off_t) : on_t;
            BIAS_WILD:
                return $urandom();
            default:
                return '0;   // zero-length echo: bad timing
        endcase
        if (sc == 0)
            return $urandom_range(1, 5000);
        dur = ((d << 16) + sc - 1) / sc;
        return (dur == 0) ? TIME_W'(1) : TIME_W'(dur);
    endfunction

    // Offers one request after an optional gap and holds it until accepted.
    task automatic send_step(input logic [TIME_W-1:0] t, input logic [LINES_W-1:0] lines);
        int gap;
        gap = (burst_left > 0) ? 0 : idle_len();
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        time_us    <= t;
        echo_lines <= lines;
        do
            @(posedge clk);
        while (!in_ready);
        now_us = t;
        items_sent++;
    endtask

    // One complete measurement of the current spot: trigger, rise, fall or timeout.
    task automatic run_reading(input meas_kind_t kind, input logic [TIME_W-1:0] start_us,
                               input logic [TIME_W-1:0] rise_after,
                               input logic [TIME_W-1:0] fall_after, input int max_waits);
        logic [TIME_W-1:0] mark;
        logic [TIME_W-1:0] lim;
        lim  = TIME_W'(cur_cfg.echo_timeout_us);
        mark = start_us;
        // The trigger step ignores the echo lines.
        send_step(start_us, LINES_W'($urandom()));
        // Quiet steps before the rise stay inside the timeout.
        if (lim != 0)
            repeat ($urandom_range(0, max_waits))
                send_step(mark + $urandom_range(0, lim - 1), echo_with(scan_spot, 1'b0));
        if (kind == MEAS_RISE_TIMEOUT)
            send_step(mark + past_limit(), echo_with(scan_spot, 1'b0));
        else
        begin
            mark = mark + rise_after;
            send_step(mark, echo_with(scan_spot, 1'b1));
            if (lim != 0)
                repeat ($urandom_range(0, max_waits))
                    send_step(mark + $urandom_range(0, lim - 1), echo_with(scan_spot, 1'b1));
            if (kind == MEAS_FALL_TIMEOUT)
                send_step(mark + past_limit(), echo_with(scan_spot, 1'b1));
            else
                send_step(mark + fall_after, echo_with(scan_spot, 1'b0));
        end
        scan_spot++;
    endtask

    // Waits until every predicted result has come back, plus a short tail.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers back to back.
    task automatic write_config(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ON_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(c.on_threshold_cm);
        @(posedge clk);
        cfg_index <= REG_OFF_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(c.off_threshold_cm);
        @(posedge clk);
        cfg_index <= REG_ECHO_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(c.echo_timeout_us);
        @(posedge clk);
        cfg_index <= REG_SCALE;
        cfg_data  <= CFG_DATA_W'(c.cm_per_us_q16);
        @(posedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    // Result-side backpressure: random stalls with long stretches of none.
    initial
    begin : result_pacing
        int stall;
        @(posedge clk);
        forever
        begin
            stall = idle_len();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8))
                @(posedge clk);
        end
    end

    // Main stimulus and verdict.
    initial
    begin : stimulus
        cfg_t              c;
        meas_kind_t        kind;
        logic [TIME_W-1:0] start_us;
        logic [TIME_W-1:0] rise_after;
        int                r;
        int                p;
        int                i;
        cur_cfg    = '{RST_ON_THRESHOLD, RST_OFF_THRESHOLD, RST_ECHO_TIMEOUT, RST_SCALE};
        scan_spot  = '0;
        now_us     = '0;
        items_sent = 0;
        burst_left = 0;
        for (i = 0; i < NUM_SPOTS; i++)
            spot_bias[i] = BIAS_NEAR;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed readings at the reset settings.
        run_reading(MEAS_VALID, '0, '0, 32'd1, 0);
        run_reading(MEAS_RISE_TIMEOUT, '1, '0, '0, 0);
        run_reading(MEAS_FALL_TIMEOUT, 32'd100, 32'd3, '0, 0);
        // Fall at the same timestamp as the rise: bad timing.
        run_reading(MEAS_VALID, 32'd5000, 32'd7, '0, 0);
        // Fall after the timestamp wrapped: also bad timing.
        run_reading(MEAS_VALID, 32'hFFFF_FF00, 32'h10, 32'h200, 0);
        // Very long echo saturates the distance.
        run_reading(MEAS_VALID, '0, '0, 32'hFFFF_0000, 0);
        run_reading(MEAS_VALID, 32'd9000, 32'd2, fall_duration(BIAS_FAR), 0);
        run_reading(MEAS_VALID, 32'd20000, 32'd2, fall_duration(BIAS_BETWEEN), 0);
        // A rise seen after the timeout has passed still wins.
        run_reading(MEAS_VALID, 32'd40000, TIME_W'(RST_ECHO_TIMEOUT) + 32'd5, 32'd300, 0);

        // Random readings under a series of register settings.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: c = '{12'd0, 12'hFFF, 20'd0, 16'hFFFF};
                1: c = '{12'hFFF, 12'd0, 20'hFFFFF, 16'd0};
                default:
                begin
                    c.on_threshold_cm  = DIST_W'($urandom_range(0, 40));
                    c.off_threshold_cm = c.on_threshold_cm + DIST_W'($urandom_range(0, 20));
                    c.echo_timeout_us  = (p == 3) ? TIMEOUT_W'($urandom_range(1, 3)) :
                                                    TIMEOUT_W'($urandom_range(50, 4000));
                    c.cm_per_us_q16    = SCALE_W'($urandom_range(300, 5000));
                end
            endcase
            drain();
            write_config(c);
            while (items_sent < DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS)
            begin
                // Biases persist for a while so that confirmations happen.
                if ($urandom_range(0, 3) == 0)
                    spot_bias[scan_spot] = spot_bias_t'($urandom_range(0, 4));
                if ($urandom_range(0, 5) == 0)
                    burst_left = $urandom_range(10, 40);
                r    = $urandom_range(0, 9);
                kind = (r == 0) ? MEAS_RISE_TIMEOUT :
                       (r == 1) ? MEAS_FALL_TIMEOUT : MEAS_VALID;
                case ($urandom_range(0, 9))
                    0:       start_us = $urandom();
                    1:       start_us = 32'hFFFF_FF00 + $urandom_range(0, 255);
                    default: start_us = now_us + $urandom_range(1, 70000);
                endcase
                rise_after = ($urandom_range(0, 3) == 0) ?
                             TIME_W'(cur_cfg.echo_timeout_us) + $urandom_range(0, 1000) :
                             TIME_W'($urandom_range(0, 15));
                run_reading(kind, start_us, rise_after, fall_duration(spot_bias[scan_spot]),
                            MAX_WAITS);
            end
        end

        // Unshaped steps at the end.
        repeat (TAIL_ITEMS)
            send_step($urandom(), LINES_W'($urandom()));
        drain();

        $display("Ran %0d scan steps over %0d register settings: %0d results checked, %0d readings.",
                 items_sent, NUM_PHASES + 1, results_checked, readings_seen);
        if (fail_count == 0)
            $display("tb_ultrasonic_occupancy_scanner_core: PASS");
        else
            $display("tb_ultrasonic_occupancy_scanner_core: FAIL");
        $finish;
    end

    // Ends a run that hangs, for instance when a result never arrives.
    initial
    begin : watchdog
        #5_000_000;
        $display("tb_ultrasonic_occupancy_scanner_core: FAIL");
        $finish;
    end

endmodule
